// ===== src/prqe_pkg.sv =====
package prqe_pkg;

    typedef enum logic {
        FUNC_INSERT  = 1'b0,
        FUNC_DEQUEUE = 1'b1
    } func_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } state_t;

    // one queue entry as held in a cell
    typedef struct packed {
        logic [1:0]  priority_req;
        logic [15:0] seq;
        logic [2:0]  req_kind;
        logic [7:0]  dev_id;
        logic [15:0] address;
        logic [4:0]  count;
        logic [31:0] wr_value;
        logic [1:0]  pool_slot;
    } entry_t;

    // s_tdata layout, last member at bit 0
    typedef struct packed {
        logic [3:0]  pad;
        logic [1:0]  pool_slot;
        logic [31:0] wr_value;
        logic [4:0]  count;
        logic [15:0] address;
        logic [7:0]  dev_id;
        logic [2:0]  req_kind;
        logic [1:0]  priority_req;
    } in_data_t;

    // m_tdata layout, last member at bit 0
    typedef struct packed {
        logic [1:0]  pad;
        logic [4:0]  high_watermark;
        logic [4:0]  depth;
        logic [1:0]  out_pool_slot;
        logic [31:0] out_wr_value;
        logic [4:0]  out_count;
        logic [15:0] out_address;
        logic [7:0]  out_dev_id;
        logic [2:0]  out_req_kind;
        logic [1:0]  out_priority;
    } out_data_t;

    typedef struct packed {
        logic evicted;
        logic ok;
    } out_user_t;

    localparam int IN_DATA_W  = $bits(in_data_t);
    localparam int OUT_DATA_W = $bits(out_data_t);
    localparam int OUT_USER_W = $bits(out_user_t);

endpackage

// ===== src/priority_request_queue_evict_unit.sv =====
// Bounded priority request queue with eviction.
// Input channel s_*: s_tuser selects the operation (0 insert, 1 dequeue best),
// s_tdata carries the request. Result channel m_*: exactly one transfer per
// accepted request; m_tuser holds ok and evicted, m_tdata the dequeued entry
// (zero for inserts) plus depth and high watermark after the operation.
// Entries live in a row of QUEUE_DEPTH cells. A search token walks the row,
// one cell per cycle, carrying the best (or worst) entry seen so far.
// Insert with room and dequeue of an empty queue go straight to the result
// state; an insert into a full queue and any other dequeue first run the
// token walk over all QUEUE_DEPTH cells. From the result state the result
// moves to the output register and the block returns to idle to accept
// the next request.
// One request is worked on at a time; the next is taken once the previous
// result has moved to the output register, so s_tready stays high while a
// finished result waits for m_tready. A stalled receiver holds the block in
// its final state only when a second result is ready behind the first one.
// Reset empties the queue and clears the sequence counter and high watermark;
// entry storage is not cleared, only occupied slots are ever read.
module priority_request_queue_evict_unit #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // priority_req, req_kind, dev_id, address, count, wr_value, pool_slot
    input  logic [prqe_pkg::IN_DATA_W-1:0]    s_tdata,
    // func
    input  logic [0:0]                        s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // out_priority, out_req_kind, out_dev_id, out_address, out_count,
    // out_wr_value, out_pool_slot, depth, high_watermark
    output logic [prqe_pkg::OUT_DATA_W-1:0]   m_tdata,
    // ok, evicted
    output logic [prqe_pkg::OUT_USER_W-1:0]   m_tuser
);

    localparam int IDX_W  = $clog2(QUEUE_DEPTH);
    localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

    prqe_pkg::state_t    state_reg, state_next;
    logic [FILL_W-1:0]   fill_reg, fill_next;
    logic [FILL_W-1:0]   peak_reg, peak_next;
    logic [15:0]         seq_reg, seq_next;
    logic                mode_reg, mode_next;
    logic                start_reg, start_next;
    prqe_pkg::entry_t    op_entry_reg, op_entry_next;
    prqe_pkg::out_data_t res_data_reg, res_data_next;
    prqe_pkg::out_user_t res_user_reg, res_user_next;
    logic                m_tvalid_reg, m_tvalid_next;
    prqe_pkg::out_data_t m_data_reg, m_data_next;
    prqe_pkg::out_user_t m_user_reg, m_user_next;

    logic                wr_en;
    logic [IDX_W-1:0]    wr_idx;
    prqe_pkg::entry_t    wr_entry;

    logic                tok   [0:QUEUE_DEPTH];
    logic                has   [0:QUEUE_DEPTH];
    logic [IDX_W-1:0]    idx   [0:QUEUE_DEPTH];
    prqe_pkg::entry_t    cand  [0:QUEUE_DEPTH];
    prqe_pkg::entry_t    entries [0:QUEUE_DEPTH-1];
    logic [QUEUE_DEPTH-1:0] tok_vec;

    prqe_pkg::in_data_t  in_d;
    prqe_pkg::entry_t    new_entry;
    prqe_pkg::entry_t    last_entry;
    prqe_pkg::entry_t    found;
    logic [FILL_W-1:0]   fill_inc;
    logic [FILL_W-1:0]   fill_dec;
    logic                load_out;

    assign tok[0]  = start_reg;
    assign has[0]  = 1'b0;
    assign idx[0]  = '0;
    assign cand[0] = '0;

    for (genvar k = 0; k < QUEUE_DEPTH; k++) begin : g_cell
        prqe_cell #(
            .CELL_IDX (k),
            .IDX_W    (IDX_W),
            .FILL_W   (FILL_W)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .mode_best (mode_reg),
            .fill      (fill_reg),
            .wr_en     (wr_en),
            .wr_idx    (wr_idx),
            .wr_entry  (wr_entry),
            .tok_in    (tok[k]),
            .has_in    (has[k]),
            .idx_in    (idx[k]),
            .cand_in   (cand[k]),
            .entry     (entries[k]),
            .tok_out   (tok[k+1]),
            .has_out   (has[k+1]),
            .idx_out   (idx[k+1]),
            .cand_out  (cand[k+1])
        );
        assign tok_vec[k] = tok[k+1];
    end

    assign in_d      = prqe_pkg::in_data_t'(s_tdata);
    assign fill_inc  = FILL_W'(fill_reg + FILL_W'(1));
    assign fill_dec  = FILL_W'(fill_reg - FILL_W'(1));
    assign found     = cand[QUEUE_DEPTH];
    assign last_entry = entries[fill_dec[IDX_W-1:0]];

    always_comb begin
        new_entry.priority_req = in_d.priority_req;
        new_entry.seq          = seq_reg;
        new_entry.req_kind     = in_d.req_kind;
        new_entry.dev_id       = in_d.dev_id;
        new_entry.address      = in_d.address;
        new_entry.count        = in_d.count;
        new_entry.wr_value     = in_d.wr_value;
        new_entry.pool_slot    = in_d.pool_slot;
    end

    always_comb begin
        state_next    = state_reg;
        fill_next     = fill_reg;
        peak_next     = peak_reg;
        seq_next      = seq_reg;
        mode_next     = mode_reg;
        start_next    = 1'b0;
        op_entry_next = op_entry_reg;
        res_data_next = res_data_reg;
        res_user_next = res_user_reg;
        wr_en         = 1'b0;
        wr_idx        = '0;
        wr_entry      = op_entry_reg;
        load_out      = 1'b0;
        s_tready      = (state_reg == prqe_pkg::ST_IDLE);

        unique case (state_reg)
            prqe_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    res_data_next = '0;
                    res_user_next = '0;
                    if (s_tuser[0] == prqe_pkg::FUNC_INSERT) begin
                        seq_next = seq_reg + 16'd1;
                        if (fill_reg < FILL_W'(QUEUE_DEPTH)) begin
                            wr_en     = 1'b1;
                            wr_idx    = fill_reg[IDX_W-1:0];
                            wr_entry  = new_entry;
                            fill_next = fill_inc;
                            peak_next = (fill_inc > peak_reg) ? fill_inc : peak_reg;
                            res_user_next.ok            = 1'b1;
                            res_data_next.depth         = 5'(fill_inc);
                            res_data_next.high_watermark = 5'(peak_next);
                            state_next = prqe_pkg::ST_DONE;
                        end else begin
                            op_entry_next = new_entry;
                            mode_next     = 1'b0;
                            start_next    = 1'b1;
                            state_next    = prqe_pkg::ST_SCAN;
                        end
                    end else if (fill_reg == '0) begin
                        res_data_next.depth          = 5'(fill_reg);
                        res_data_next.high_watermark = 5'(peak_reg);
                        state_next = prqe_pkg::ST_DONE;
                    end else begin
                        mode_next  = 1'b1;
                        start_next = 1'b1;
                        state_next = prqe_pkg::ST_SCAN;
                    end
                end
            end

            prqe_pkg::ST_SCAN: begin
                if (tok[QUEUE_DEPTH]) begin
                    if (mode_reg) begin
                        res_user_next.ok              = 1'b1;
                        res_data_next.out_priority    = found.priority_req;
                        res_data_next.out_req_kind    = found.req_kind;
                        res_data_next.out_dev_id      = found.dev_id;
                        res_data_next.out_address     = found.address;
                        res_data_next.out_count       = found.count;
                        res_data_next.out_wr_value    = found.wr_value;
                        res_data_next.out_pool_slot   = found.pool_slot;
                        fill_next = fill_dec;
                        // last occupied slot fills the hole
                        if (idx[QUEUE_DEPTH] != fill_dec[IDX_W-1:0]) begin
                            wr_en    = 1'b1;
                            wr_idx   = idx[QUEUE_DEPTH];
                            wr_entry = last_entry;
                        end
                        res_data_next.depth = 5'(fill_dec);
                    end else begin
                        if (found.priority_req > op_entry_reg.priority_req) begin
                            wr_en     = 1'b1;
                            wr_idx    = idx[QUEUE_DEPTH];
                            wr_entry  = op_entry_reg;
                            res_user_next.ok      = 1'b1;
                            res_user_next.evicted = 1'b1;
                            peak_next = (fill_reg > peak_reg) ? fill_reg : peak_reg;
                        end
                        res_data_next.depth = 5'(fill_reg);
                    end
                    res_data_next.high_watermark = 5'(peak_next);
                    state_next = prqe_pkg::ST_DONE;
                end
            end

            prqe_pkg::ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    load_out   = 1'b1;
                    state_next = prqe_pkg::ST_IDLE;
                end
            end

            default: begin
                state_next = prqe_pkg::ST_IDLE;
            end
        endcase

        m_data_next = m_data_reg;
        m_user_next = m_user_reg;
        if (load_out) begin
            m_tvalid_next = 1'b1;
            m_data_next   = res_data_reg;
            m_user_next   = res_user_reg;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end else begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= prqe_pkg::ST_IDLE;
            fill_reg     <= '0;
            peak_reg     <= '0;
            seq_reg      <= '0;
            mode_reg     <= 1'b0;
            start_reg    <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            fill_reg     <= fill_next;
            peak_reg     <= peak_next;
            seq_reg      <= seq_next;
            mode_reg     <= mode_next;
            start_reg    <= start_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_entry_reg <= op_entry_next;
        res_data_reg <= res_data_next;
        res_user_reg <= res_user_next;
        m_data_reg   <= m_data_next;
        m_user_reg   <= m_user_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

    // at most one search token in the row
    a_one_token: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({tok_vec, start_reg}))
        else $error("more than one search token in flight");

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (fill_reg <= FILL_W'(QUEUE_DEPTH)) && (peak_reg >= fill_reg))
        else $error("fill count out of range or above watermark");

    // cells must not change under a running search
    a_no_write_in_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == prqe_pkg::ST_SCAN && !tok[QUEUE_DEPTH]) |-> !wr_en)
        else $error("entry written during search");

    a_dequeue_found: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == prqe_pkg::ST_SCAN && tok[QUEUE_DEPTH]) |-> has[QUEUE_DEPTH])
        else $error("search finished without a candidate");

endmodule

// ===== src/prqe_cell.sv =====
module prqe_cell #(
    parameter int CELL_IDX = 0,
    parameter int IDX_W    = 4,
    parameter int FILL_W   = 5
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  mode_best,   // 1: min search (dequeue), 0: victim search
    input  logic [FILL_W-1:0]     fill,
    input  logic                  wr_en,
    input  logic [IDX_W-1:0]      wr_idx,
    input  prqe_pkg::entry_t      wr_entry,
    input  logic                  tok_in,
    input  logic                  has_in,
    input  logic [IDX_W-1:0]      idx_in,
    input  prqe_pkg::entry_t      cand_in,
    output prqe_pkg::entry_t      entry,
    output logic                  tok_out,
    output logic                  has_out,
    output logic [IDX_W-1:0]      idx_out,
    output prqe_pkg::entry_t      cand_out
);

    prqe_pkg::entry_t entry_reg;
    prqe_pkg::entry_t cand_reg, cand_next;
    logic             tok_reg;
    logic             has_reg, has_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             active;
    logic             better;
    logic             worse;

    assign active = FILL_W'(CELL_IDX) < fill;

    assign better = (entry_reg.priority_req < cand_in.priority_req) ||
                    ((entry_reg.priority_req == cand_in.priority_req) &&
                     (entry_reg.seq < cand_in.seq));
    assign worse  = (entry_reg.priority_req > cand_in.priority_req) ||
                    ((entry_reg.priority_req == cand_in.priority_req) &&
                     (entry_reg.seq > cand_in.seq));

    // earlier cell wins ties: own entry only replaces on a strict win
    always_comb begin
        has_next  = has_in;
        idx_next  = idx_in;
        cand_next = cand_in;
        if (active && (!has_in || (mode_best ? better : worse))) begin
            has_next  = 1'b1;
            idx_next  = IDX_W'(CELL_IDX);
            cand_next = entry_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en && (wr_idx == IDX_W'(CELL_IDX))) begin
            entry_reg <= wr_entry;
        end
        cand_reg <= cand_next;
        idx_reg  <= idx_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_reg <= 1'b0;
            has_reg <= 1'b0;
        end else begin
            tok_reg <= tok_in;
            has_reg <= has_next;
        end
    end

    assign entry    = entry_reg;
    assign tok_out  = tok_reg;
    assign has_out  = has_reg;
    assign idx_out  = idx_reg;
    assign cand_out = cand_reg;

endmodule

// ===== verif/request_queue_checker.sv =====
`timescale 1ns / 100ps

module request_queue_checker #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    input  logic                              s_tready,
    input  logic [prqe_pkg::IN_DATA_W-1:0]    s_tdata,
    input  logic [0:0]                        s_tuser,
    input  logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic [prqe_pkg::OUT_DATA_W-1:0]   m_tdata,
    input  logic [prqe_pkg::OUT_USER_W-1:0]   m_tuser,
    output int                                mismatch_count,
    output int                                outstanding
);
    import prqe_pkg::*;

    typedef struct packed {
        out_user_t user;
        out_data_t data;
    } queue_result_t;

    // shadow copy of the queue
    entry_t        held[QUEUE_DEPTH];
    int            held_count  = 0;
    logic [15:0]   seq_counter = '0;
    int            peak_depth  = 0;

    queue_result_t expected_results[$];
    int            errors       = 0;
    int            result_index = 0;

    function automatic queue_result_t predict_request(input func_t op, input in_data_t req);
        queue_result_t res;
        entry_t        fresh;
        int            pick;
        res = '0;
        if (op == FUNC_INSERT) begin
            fresh.priority_req = req.priority_req;
            fresh.seq          = seq_counter;
            fresh.req_kind     = req.req_kind;
            fresh.dev_id       = req.dev_id;
            fresh.address      = req.address;
            fresh.count        = req.count;
            fresh.wr_value     = req.wr_value;
            fresh.pool_slot    = req.pool_slot;
            // sequence number is consumed even if the request gets dropped
            seq_counter = seq_counter + 16'd1;
            if (held_count < QUEUE_DEPTH) begin
                held[held_count] = fresh;
                held_count++;
                res.user.ok = 1'b1;
            end else begin
                // victim: worst priority, newest among equals
                pick = 0;
                for (int i = 1; i < QUEUE_DEPTH; i++) begin
                    if (held[i].priority_req > held[pick].priority_req ||
                        (held[i].priority_req == held[pick].priority_req &&
                         held[i].seq > held[pick].seq))
                        pick = i;
                end
                if (held[pick].priority_req > fresh.priority_req) begin
                    held[pick]       = fresh;
                    res.user.ok      = 1'b1;
                    res.user.evicted = 1'b1;
                end
            end
            if (res.user.ok && held_count > peak_depth)
                peak_depth = held_count;
        end else if (held_count > 0) begin
            // best priority, oldest among equals
            pick = 0;
            for (int i = 1; i < held_count; i++) begin
                if (held[i].priority_req < held[pick].priority_req ||
                    (held[i].priority_req == held[pick].priority_req &&
                     held[i].seq < held[pick].seq))
                    pick = i;
            end
            res.user.ok              = 1'b1;
            res.data.out_priority    = held[pick].priority_req;
            res.data.out_req_kind    = held[pick].req_kind;
            res.data.out_dev_id      = held[pick].dev_id;
            res.data.out_address     = held[pick].address;
            res.data.out_count       = held[pick].count;
            res.data.out_wr_value    = held[pick].wr_value;
            res.data.out_pool_slot   = held[pick].pool_slot;
            held_count--;
            // last entry fills the hole
            if (pick < held_count)
                held[pick] = held[held_count];
        end
        res.data.depth          = 5'(held_count);
        res.data.high_watermark = 5'(peak_depth);
        return res;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got) begin
            errors++;
            if (errors <= 10)
                $display("[%0t] result %0d: %s expected 0x%0h, got 0x%0h",
                         $time, result_index, name, want, got);
        end
    endfunction

    always @(posedge aclk) begin : watch_channels
        queue_result_t want;
        out_user_t     got_user;
        out_data_t     got_data;
        if (!aresetn) begin
            held_count  = 0;
            seq_counter = '0;
            peak_depth  = 0;
            expected_results.delete();
        end else begin
            if (s_tvalid && s_tready)
                expected_results.push_back(
                    predict_request(func_t'(s_tuser[0]), in_data_t'(s_tdata)));
            if (m_tvalid && m_tready) begin
                got_user = out_user_t'(m_tuser);
                got_data = out_data_t'(m_tdata);
                if (expected_results.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("[%0t] result %0d: unexpected transfer, tuser 0x%0h tdata 0x%0h",
                                 $time, result_index, m_tuser, m_tdata);
                end else begin
                    want = expected_results.pop_front();
                    check_field("ok", 32'(want.user.ok), 32'(got_user.ok));
                    check_field("evicted", 32'(want.user.evicted), 32'(got_user.evicted));
                    check_field("out_priority", 32'(want.data.out_priority),
                                32'(got_data.out_priority));
                    check_field("out_req_kind", 32'(want.data.out_req_kind),
                                32'(got_data.out_req_kind));
                    check_field("out_dev_id", 32'(want.data.out_dev_id),
                                32'(got_data.out_dev_id));
                    check_field("out_address", 32'(want.data.out_address),
                                32'(got_data.out_address));
                    check_field("out_count", 32'(want.data.out_count),
                                32'(got_data.out_count));
                    check_field("out_wr_value", want.data.out_wr_value,
                                got_data.out_wr_value);
                    check_field("out_pool_slot", 32'(want.data.out_pool_slot),
                                32'(got_data.out_pool_slot));
                    check_field("depth", 32'(want.data.depth), 32'(got_data.depth));
                    check_field("high_watermark", 32'(want.data.high_watermark),
                                32'(got_data.high_watermark));
                end
                result_index++;
            end
        end
        outstanding    <= expected_results.size();
        mismatch_count <= errors;
    end

endmodule

// ===== verif/tb_priority_request_queue_evict_unit.sv =====
`timescale 1ns / 100ps

module tb_priority_request_queue_evict_unit;
    import prqe_pkg::*;

    localparam int QDEPTH        = 16;
    localparam int RANDOM_ITEMS  = 1850;
    localparam int CYCLE_LIMIT   = 600000;
    localparam int LONG_HOLD     = 300;
    localparam int HOLD_AT_ITEM  = 400;
    localparam int SETTLE_CYCLES = 40;

    logic                    aclk     = 1'b0;
    logic                    aresetn  = 1'b0;
    logic                    s_tvalid = 1'b0;
    logic                    s_tready;
    logic [IN_DATA_W-1:0]    s_tdata  = '0;
    logic [0:0]              s_tuser  = '0;
    logic                    m_tvalid;
    logic                    m_tready = 1'b0;
    logic [OUT_DATA_W-1:0]   m_tdata;
    logic [OUT_USER_W-1:0]   m_tuser;

    int   mismatch_count;
    int   outstanding;
    int   rand_sent     = 0;
    int   cycle_cnt     = 0;
    logic long_hold     = 1'b0;
    int   rx_stall_left = 0;
    int   rx_quiet_left = 0;

    always #10 aclk = ~aclk;

    priority_request_queue_evict_unit #(
        .QUEUE_DEPTH (QDEPTH)
    ) i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    request_queue_checker #(
        .QUEUE_DEPTH (QDEPTH)
    ) i_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .mismatch_count (mismatch_count),
        .outstanding    (outstanding)
    );

    function automatic in_data_t random_request();
        in_data_t req;
        req = '0;
        req.priority_req = ($urandom_range(7) == 0) ? 2'd3 : 2'($urandom_range(2));
        req.req_kind     = 3'($urandom);
        req.dev_id       = 8'($urandom);
        req.address      = 16'($urandom);
        // mostly legal register counts, now and then the full 5-bit range
        req.count        = ($urandom_range(3) == 0) ? 5'($urandom) : 5'($urandom_range(16));
        req.wr_value     = $urandom;
        req.pool_slot    = 2'($urandom);
        return req;
    endfunction

    function automatic in_data_t make_request(input logic [1:0] prio, input logic [2:0] kind,
                                              input logic [7:0] sid, input logic [15:0] addr,
                                              input logic [4:0] cnt, input logic [31:0] wval,
                                              input logic [1:0] slot);
        in_data_t req;
        req = '0;
        req.priority_req = prio;
        req.req_kind     = kind;
        req.dev_id       = sid;
        req.address      = addr;
        req.count        = cnt;
        req.wr_value     = wval;
        req.pool_slot    = slot;
        return req;
    endfunction

    task automatic push_request(input func_t op, input in_data_t req, input int gap);
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= req;
        do @(posedge aclk); while (!s_tready);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic wait_results_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (outstanding != 0);
    endtask

    // result side pacing: random stall per transfer, occasional runs with none
    always @(posedge aclk) begin : rx_pacing
        int stall;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (long_hold) begin
            m_tready <= 1'b0;
        end else if (m_tvalid && m_tready) begin
            if (rx_quiet_left > 0) begin
                stall = 0;
                rx_quiet_left <= rx_quiet_left - 1;
            end else begin
                stall = $urandom_range(16);
                if ($urandom_range(39) == 0)
                    rx_quiet_left <= 30;
            end
            m_tready      <= (stall == 0);
            rx_stall_left <= stall;
        end else if (rx_stall_left > 0) begin
            rx_stall_left <= rx_stall_left - 1;
            m_tready      <= (rx_stall_left == 1);
        end else begin
            m_tready <= 1'b1;
        end
    end

    // long receiver stall so both result slots fill and s_tready drops
    initial begin
        wait (rand_sent >= HOLD_AT_ITEM);
        @(posedge aclk);
        long_hold <= 1'b1;
        repeat (LONG_HOLD) @(posedge aclk);
        long_hold <= 1'b0;
    end

    initial begin
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_cnt++;
        end
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        int       phase_len;
        int       deq_pct;
        logic     idle_on;
        func_t    op;
        in_data_t req;

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // empty queue, then field extremes through insert and dequeue
        push_request(FUNC_DEQUEUE, '0, $urandom_range(16));
        push_request(FUNC_INSERT, make_request(2'd0, '0, '0, '0, '0, '0, '0), 0);
        push_request(FUNC_INSERT, make_request(2'd3, '1, '1, '1, '1, '1, '1), $urandom_range(16));
        push_request(FUNC_DEQUEUE, '0, 0);
        push_request(FUNC_DEQUEUE, '1, $urandom_range(16));
        push_request(FUNC_DEQUEUE, '0, 0);

        // fill up with alternating priorities two and one
        for (int i = 0; i < QDEPTH; i++) begin
            req = random_request();
            req.priority_req = (i % 2 == 0) ? 2'd2 : 2'd1;
            push_request(FUNC_INSERT, req, (i % 3 == 0) ? int'($urandom_range(16)) : 0);
        end

        // full queue: equal priority is dropped, better one evicts, priority three dropped
        req = random_request();
        req.priority_req = 2'd2;
        push_request(FUNC_INSERT, req, 0);
        req = random_request();
        req.priority_req = 2'd1;
        push_request(FUNC_INSERT, req, $urandom_range(16));
        req = random_request();
        req.priority_req = 2'd3;
        push_request(FUNC_INSERT, req, 0);

        // random phases, each with its own insert/dequeue mix and idle setting
        while (rand_sent < RANDOM_ITEMS) begin
            phase_len = $urandom_range(60, 20);
            deq_pct   = 10 + 20 * $urandom_range(4);
            idle_on   = ($urandom_range(3) != 0);
            for (int k = 0; k < phase_len && rand_sent < RANDOM_ITEMS; k++) begin
                op = ($urandom_range(99) < deq_pct) ? FUNC_DEQUEUE : FUNC_INSERT;
                push_request(op, random_request(), idle_on ? int'($urandom_range(16)) : 0);
                rand_sent++;
                if (rand_sent == RANDOM_ITEMS / 2)
                    wait_results_drained();
            end
        end

        wait_results_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// ===== priority_request_queue_evict_unit.f =====
src/prqe_pkg.sv
src/prqe_cell.sv
src/priority_request_queue_evict_unit.sv
verif/request_queue_checker.sv
verif/tb_priority_request_queue_evict_unit.sv
